@@ sv/swmc_pkg.sv @@
// ----------------------------------------------------------------------------
// swmc_pkg: shared types and constants of the sliding window median cost block
// Sizes of the sample store and sorted chain, derived widths, control words.
// ----------------------------------------------------------------------------
`default_nettype none

package swmc_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int CFG_W       = 7;
	localparam int COST_W      = 38;

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
	localparam int ACC_W  = SUM_W + 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic             shift;
		logic             rotate;
		logic [CNT_W-1:0] k;
	} hist_ctrl_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic drain;
	} sort_ctrl_t;

endpackage

`default_nettype wire

@@ sv/swmc_hist_cell.sv @@
// ----------------------------------------------------------------------------
// swmc_hist_cell: one cell of the recent sample chain
// Shifts in the newer sample on arrival and rotates within the window on feed.
// ----------------------------------------------------------------------------
`default_nettype none

module swmc_hist_cell (
	input  wire                         clk,
	input  wire swmc_pkg::hist_ctrl_t   ctrl,
	input  wire [swmc_pkg::SLOT_W-1:0]  idx,
	input  wire swmc_pkg::sample_t      left_v,
	input  wire swmc_pkg::sample_t      right_v,
	input  wire swmc_pkg::sample_t      head_v,
	output swmc_pkg::sample_t           v
);

	swmc_pkg::sample_t             v_q;
	logic [swmc_pkg::CNT_W-1:0]    pos;
	logic [swmc_pkg::CNT_W-1:0]    last;

	assign pos  = swmc_pkg::CNT_W'(idx);
	assign last = ctrl.k - swmc_pkg::CNT_W'(1);
	assign v    = v_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			v_q <= left_v;
		end else if (ctrl.rotate) begin
			if (pos < last) begin
				v_q <= right_v;
			end else if (pos == last) begin
				v_q <= head_v;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/swmc_sort_cell.sv @@
// ----------------------------------------------------------------------------
// swmc_sort_cell: one cell of the sorted insertion chain
// Takes a broadcast value in order, pushes larger entries right, drains left.
// ----------------------------------------------------------------------------
`default_nettype none

module swmc_sort_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire swmc_pkg::sort_ctrl_t  ctrl,
	input  wire swmc_pkg::sample_t     x,
	input  wire swmc_pkg::sample_t     prev_v,
	input  wire                        prev_full,
	input  wire                        prev_gt,
	input  wire swmc_pkg::sample_t     next_v,
	input  wire                        next_full,
	output swmc_pkg::sample_t          v,
	output logic                       full,
	output logic                       gt
);

	swmc_pkg::sample_t v_q;
	logic              full_q;

	assign v    = v_q;
	assign full = full_q;
	assign gt   = !full_q || (x < v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (ctrl.clear) begin
			full_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (gt && prev_gt) begin
				full_q <= prev_full;
			end else if (gt) begin
				full_q <= 1'b1;
			end
		end else if (ctrl.drain) begin
			full_q <= next_full;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (gt && prev_gt) begin
				v_q <= prev_v;
			end else if (gt) begin
				v_q <= x;
			end
		end else if (ctrl.drain) begin
			v_q <= next_v;
		end
	end

endmodule

`default_nettype wire

@@ sv/sliding_window_median_cost.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_cost: lower median and absolute deviation sum
// Input words (sample) come on in_valid/in_stall, results (median, cost) leave
// on out_valid/out_stall, window_size is written on cfg_valid/cfg_ready.
// Once k samples are held, each accepted sample yields a result: the feed
// state moves the window into the sorted cell chain, the drain state moves
// it into the half sums, the multiply state scales the median by the half
// counts and the sum state forms the cost. No new sample is accepted until
// the block is back in idle; a sample that yields no result leaves it idle.
// A finished result waits in the output register under stall while a new
// sample is taken; the block holds before writing the following result
// until that word has left. Reset empties the store and sets window_size
// to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_cost (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire signed [swmc_pkg::SAMPLE_BITS-1:0] sample,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic signed [swmc_pkg::SAMPLE_BITS-1:0] median,
	output logic [swmc_pkg::COST_W-1:0]    cost,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [swmc_pkg::CFG_W-1:0]      window_size
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FEED  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_MULT  = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;

	localparam int N = swmc_pkg::WINDOW_MAX;
	localparam int CW = swmc_pkg::CNT_W;

	logic [2:0]                          state_q;
	logic [CW-1:0]                       cnt_q;
	logic [CW-1:0]                       fill_q;
	logic [swmc_pkg::CFG_W-1:0]          window_size_q;
	logic signed [swmc_pkg::SUM_W-1:0]   lsum_q;
	logic signed [swmc_pkg::SUM_W-1:0]   usum_q;
	swmc_pkg::sample_t                   med_q;
	logic signed [swmc_pkg::ACC_W-1:0]   pl_q;
	logic signed [swmc_pkg::ACC_W-1:0]   pu_q;
	logic signed [swmc_pkg::ACC_W-1:0]   diff_q;
	swmc_pkg::sample_t                   median_q;
	logic [swmc_pkg::COST_W-1:0]         cost_q;
	logic                                out_valid_q;

	logic [CW-1:0]                       k;
	logic [CW-1:0]                       lower_n;
	logic [CW-1:0]                       upper_n;
	logic [CW-1:0]                       fill_nxt;
	logic                                accept;
	logic                                out_free;
	logic signed [swmc_pkg::ACC_W-1:0]   acc;
	swmc_pkg::sample_t                   head;

	swmc_pkg::hist_ctrl_t                hctrl;
	swmc_pkg::sort_ctrl_t                sctrl;
	swmc_pkg::sample_t                   hist_v [N];
	swmc_pkg::sample_t                   sort_v [N];
	logic [N-1:0]                        sort_full;
	logic [N-1:0]                        sort_gt;

	always_comb begin
		if (window_size_q == '0) begin
			k = CW'(1);
		end else if (32'(window_size_q) > 32'(N)) begin
			k = CW'(N);
		end else begin
			k = CW'(window_size_q);
		end
	end

	assign lower_n  = CW'((32'(k) + 32'd1) >> 1);
	assign upper_n  = k - lower_n;
	assign fill_nxt = (32'(fill_q) == 32'(N)) ? fill_q : fill_q + CW'(1);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign acc      = diff_q + pl_q - pu_q;
	assign head     = sort_v[0];

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign cost      = cost_q;

	assign hctrl.shift  = accept;
	assign hctrl.rotate = (state_q == ST_FEED);
	assign hctrl.k      = k;
	assign sctrl.clear  = accept;
	assign sctrl.insert = (state_q == ST_FEED);
	assign sctrl.drain  = (state_q == ST_DRAIN);

	for (genvar i = 0; i < N; i++) begin : g_cell
		swmc_hist_cell u_hist (
			.clk     (clk),
			.ctrl    (hctrl),
			.idx     (swmc_pkg::SLOT_W'(i)),
			.left_v  ((i == 0) ? sample : hist_v[(i == 0) ? 0 : i - 1]),
			.right_v ((i == N - 1) ? hist_v[0] : hist_v[(i == N - 1) ? 0 : i + 1]),
			.head_v  (hist_v[0]),
			.v       (hist_v[i])
		);

		swmc_sort_cell u_sort (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (sctrl),
			.x         (hist_v[0]),
			.prev_v    ((i == 0) ? hist_v[0] : sort_v[(i == 0) ? 0 : i - 1]),
			.prev_full ((i == 0) ? 1'b0 : sort_full[(i == 0) ? 0 : i - 1]),
			.prev_gt   ((i == 0) ? 1'b0 : sort_gt[(i == 0) ? 0 : i - 1]),
			.next_v    ((i == N - 1) ? hist_v[0] : sort_v[(i == N - 1) ? 0 : i + 1]),
			.next_full ((i == N - 1) ? 1'b0 : sort_full[(i == N - 1) ? 0 : i + 1]),
			.v         (sort_v[i]),
			.full      (sort_full[i]),
			.gt        (sort_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swmc_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= window_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SUM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_nxt;
						cnt_q  <= '0;
						if (fill_nxt >= k) begin
							state_q <= ST_FEED;
						end
					end
				end
				ST_FEED: begin
					if (cnt_q == k - CW'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == k - CW'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_MULT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_MULT: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lsum_q <= '0;
			usum_q <= '0;
		end
		if (state_q == ST_DRAIN) begin
			if (cnt_q < lower_n) begin
				lsum_q <= lsum_q + swmc_pkg::SUM_W'(head);
			end else begin
				usum_q <= usum_q + swmc_pkg::SUM_W'(head);
			end
			if (cnt_q == lower_n - CW'(1)) begin
				med_q <= head;
			end
		end
		if (state_q == ST_MULT) begin
			pl_q   <= swmc_pkg::ACC_W'(med_q)
				* swmc_pkg::ACC_W'($signed({1'b0, lower_n}));
			pu_q   <= swmc_pkg::ACC_W'(med_q)
				* swmc_pkg::ACC_W'($signed({1'b0, upper_n}));
			diff_q <= swmc_pkg::ACC_W'(usum_q) - swmc_pkg::ACC_W'(lsum_q);
		end
		if (state_q == ST_SUM && out_free) begin
			median_q <= med_q;
			cost_q   <= acc[swmc_pkg::COST_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_sliding_window_median_cost.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_median_cost: self-checking bench for the median cost block
// Streams signed samples through several window sizes, including zero and
// sizes beyond the store depth, and changes the size between phases while the
// stored samples are kept. Once k are held, a behavioural model sorts the
// last k samples on every accepted word and queues the lower median and the
// absolute deviation sum, compared with each result leaving the block. The
// sender works in bursts with gaps; the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_cost;

	localparam int RANDOM_ITEMS   = 1850;
	localparam int SETTLE_CYCLES  = 2 * swmc_pkg::WINDOW_MAX + 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int CFG_MAX        = (1 << swmc_pkg::CFG_W) - 1;

	localparam swmc_pkg::sample_t S_MIN = {1'b1, {(swmc_pkg::SAMPLE_BITS-1){1'b0}}};
	localparam swmc_pkg::sample_t S_MAX = {1'b0, {(swmc_pkg::SAMPLE_BITS-1){1'b1}}};

	typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_t;
	typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_RAMP} fill_mode_t;

	typedef struct packed {
		swmc_pkg::sample_t          median;
		logic [swmc_pkg::COST_W-1:0] cost;
	} median_cost_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	swmc_pkg::sample_t sample;
	logic out_valid;
	logic out_stall;
	swmc_pkg::sample_t median;
	logic [swmc_pkg::COST_W-1:0] cost;
	logic cfg_valid;
	logic cfg_ready;
	logic [swmc_pkg::CFG_W-1:0] window_size;

	sliding_window_median_cost uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.median     (median),
		.cost       (cost),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_size(window_size)
	);

	swmc_pkg::sample_t sample_q[$];
	median_cost_t median_cost_q[$];
	int fails = 0;

	// model state
	swmc_pkg::sample_t history [swmc_pkg::WINDOW_MAX];
	int unsigned held_count = 0;
	int unsigned next_slot  = 0;
	logic [swmc_pkg::CFG_W-1:0] window_reg = swmc_pkg::CFG_W'(1);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_sample(input swmc_pkg::sample_t s);
		sample_q.insert(sample_q.size(), s);
	endfunction

	function automatic void absorb_sample(input swmc_pkg::sample_t s);
		int unsigned k, lower_n, i, j;
		longint ordered [swmc_pkg::WINDOW_MAX];
		longint x, mid;
		longint unsigned total;
		median_cost_t r;
		history[next_slot] = s;
		next_slot = (next_slot + 1) % swmc_pkg::WINDOW_MAX;
		if (held_count < swmc_pkg::WINDOW_MAX)
			held_count++;
		if (window_reg == 0)
			k = 1;
		else if (window_reg > swmc_pkg::WINDOW_MAX)
			k = swmc_pkg::WINDOW_MAX;
		else
			k = window_reg;
		if (held_count < k)
			return;
		for (i = 0; i < k; i++) begin
			x = history[(next_slot + swmc_pkg::WINDOW_MAX - 1 - i) % swmc_pkg::WINDOW_MAX];
			j = i;
			while (j > 0 && ordered[j-1] > x) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = x;
		end
		lower_n = (k + 1) / 2;
		mid = ordered[lower_n-1];
		total = 0;
		for (i = 0; i < k; i++)
			total += (ordered[i] >= mid) ? ordered[i] - mid : mid - ordered[i];
		r.median = swmc_pkg::sample_t'(mid);
		r.cost = swmc_pkg::COST_W'(total);
		median_cost_q.insert(median_cost_q.size(), r);
	endfunction

	// sender: bursts of words with gaps between them
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		logic nxt_valid;
		swmc_pkg::sample_t nxt_sample;
		nxt_valid = in_valid;
		nxt_sample = sample;
		if (arst_n) begin
			if (in_valid && !in_stall)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (sample_q.size() != 0) begin
					nxt_sample = sample_q.pop_front();
					nxt_valid = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
			end
		end
		in_valid <= nxt_valid;
		sample <= nxt_sample;
	end

	// receiver stall pattern
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= $urandom_range(0, 1);
			STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
			default: out_stall <= (mode_left % 24) < 16;
		endcase
	end

	// monitor: check results, then update the model
	always @(posedge clk) begin
		median_cost_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (median_cost_q.size() == 0) begin
					$error("unexpected result: median %0d cost %0d", median, cost);
					fails++;
				end else begin
					want = median_cost_q.pop_front();
					if (median !== want.median) begin
						$error("median: expected %0d, actual %0d", want.median, median);
						fails++;
					end
					if (cost !== want.cost) begin
						$error("cost: expected %0d, actual %0d", want.cost, cost);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				window_reg = window_size;
			if (in_valid && !in_stall)
				absorb_sample(sample);
		end
	end

	// watchdog on cycles without any accepted word
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic settle();
		while (sample_q.size() != 0 || in_valid || median_cost_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		window_size <= swmc_pkg::CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n, sent;
		int win;
		fill_mode_t fill;
		swmc_pkg::sample_t ramp, step, s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		window_size = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// window of one after reset: extremes and alternating bits
		queue_sample(S_MIN);
		queue_sample(S_MAX);
		queue_sample(swmc_pkg::sample_t'(0));
		queue_sample(swmc_pkg::sample_t'(-1));
		queue_sample(swmc_pkg::sample_t'(32'h5555_5555));
		queue_sample(swmc_pkg::sample_t'(32'haaaa_aaaa));
		settle();
		// zero size behaves as one
		write_window(0);
		queue_sample(swmc_pkg::sample_t'(7));
		queue_sample(S_MIN);
		settle();
		// odd window, widest spread and duplicates
		write_window(3);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample(S_MAX);
		queue_sample(swmc_pkg::sample_t'(5));
		queue_sample(swmc_pkg::sample_t'(5));
		queue_sample(swmc_pkg::sample_t'(5));
		settle();
		// even window takes the lower median
		write_window(4);
		queue_sample(swmc_pkg::sample_t'(-3));
		queue_sample(swmc_pkg::sample_t'(10));
		queue_sample(swmc_pkg::sample_t'(2));
		queue_sample(swmc_pkg::sample_t'(-8));
		settle();
		// oversize clamps to the store depth, store not yet full
		write_window(CFG_MAX);
		queue_sample(S_MAX);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		settle();
		// shrink mid-stream: stored samples form the window at once
		write_window(2);
		queue_sample(S_MIN);
		queue_sample(swmc_pkg::sample_t'(1));
		settle();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: win = 0;
				1: win = swmc_pkg::WINDOW_MAX;
				2: win = $urandom_range(swmc_pkg::WINDOW_MAX + 1, CFG_MAX);
				3, 4, 5: win = $urandom_range(9, 40);
				default: win = $urandom_range(1, 8);
			endcase
			n = (win <= 8) ? $urandom_range(20, 100) : $urandom_range(8, 40);
			fill = fill_mode_t'($urandom_range(0, 3));
			ramp = swmc_pkg::sample_t'($urandom);
			step = swmc_pkg::sample_t'(int'($urandom_range(0, 2000)) - 1000);
			write_window(win);
			repeat (n) begin
				case (fill)
					FILL_FULL: s = swmc_pkg::sample_t'($urandom);
					FILL_NARROW: s = swmc_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
					FILL_EXTREME:
						case ($urandom_range(0, 3))
							0: s = S_MIN;
							1: s = S_MAX;
							2: s = swmc_pkg::sample_t'(0);
							default: s = swmc_pkg::sample_t'(-1);
						endcase
					default: begin
						ramp = ramp + step;
						s = ramp;
					end
				endcase
				queue_sample(s);
			end
			sent += n;
			settle();
		end

		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
sv/swmc_pkg.sv
sv/swmc_hist_cell.sv
sv/swmc_sort_cell.sv
sv/sliding_window_median_cost.sv
tb/tb_sliding_window_median_cost.sv
